// ----- hw/rtl/fha_pkg.sv -----
// fha_pkg: shared types and constants for the first-fit heap allocator
// used by fha_ctrl, fha_datapath and first_fit_heap_allocator
// no dependencies
package fha_pkg;

  localparam int REQ_W  = 17;
  localparam int ADDR_W = 16;
  localparam int CFG_W  = 17;
  localparam int STAT_W = 2;
  localparam int PADDR_W = 3;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd3;

  localparam logic [PADDR_W-1:0] REG_POOL_BYTES = 3'd0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_INIT,
    DP_LOAD,
    DP_ALN,
    DP_ASZ,
    DP_RD,
    DP_CHK,
    DP_FITSET,
    DP_MVRD,
    DP_MVWR,
    DP_WRA,
    DP_WRB,
    DP_TAIL,
    DP_APPEND,
    DP_NXRD,
    DP_NXCAP,
    DP_NONX,
    DP_MERGE,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [STAT_W-1:0]   stat;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic zero_req;
    logic match;
    logic last;
    logic split;
    logic mv_any;
    logic mv_done;
    logic has_next;
    logic app_ok;
  } dp_sts_t;

endpackage

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// first_fit_heap_allocator: one request per start, one result strobe per request
// allocate: walks the headers until one fits, moving later headers up on a split
// free: walks the headers to the block, merges free neighbours and moves headers down; one item at a time
// the header store has one read and one write port; the walk reads one header at a time
// reset: the first state after reset writes the first header, then busy drops
// the receiver cannot stall; out_valid lasts one cycle
module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = 65536,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [fha_pkg::REQ_W-1:0]          in_request_size,
  input  logic [fha_pkg::ADDR_W-1:0]         in_block_address,
  output logic                               out_valid,
  output logic [fha_pkg::STAT_W-1:0]         out_status,
  output logic [fha_pkg::ADDR_W-1:0]         out_payload_address,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fha_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import fha_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        cfg_we;
  logic [31:0] pool_val;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_POOL_BYTES);
  assign prdata = (paddr == REG_POOL_BYTES) ? pool_val : 32'd0;

  fha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fha_datapath #(
    .POOL_BYTES   (POOL_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .cfg_we              (cfg_we),
    .cfg_val             (pwdata[CFG_W-1:0]),
    .pool_val            (pool_val),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_payload_address (out_payload_address)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> out_payload_address == '0)
    else $error("address on a failed request");
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result without a finished request");

endmodule

// ----- hw/rtl/fha_datapath.sv -----
// fha_datapath: header store, walk registers, size rounding and result registers
// depends on fha_pkg; driven by fha_ctrl commands
module fha_datapath #(
  parameter int POOL_BYTES   = 65536,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fha_pkg::dp_cmd_t                    cmd,
  output fha_pkg::dp_sts_t                    sts,
  input  logic                                in_op,
  input  logic [fha_pkg::REQ_W-1:0]           in_request_size,
  input  logic [fha_pkg::ADDR_W-1:0]          in_block_address,
  input  logic                                cfg_we,
  input  logic [fha_pkg::CFG_W-1:0]           cfg_val,
  output logic [31:0]                         pool_val,
  output logic                                out_valid,
  output logic [fha_pkg::STAT_W-1:0]          out_status,
  output logic [fha_pkg::ADDR_W-1:0]          out_payload_address
);
  import fha_pkg::*;

  localparam int MAX_BLOCKS = POOL_BYTES / HEADER_BYTES + 1;
  localparam int OFF_W = $clog2(POOL_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ASZ_W = REQ_W + 1;
  localparam int SUM_W = ((OFF_W > ASZ_W) ? OFF_W : ASZ_W) + 2;
  localparam int ENT_W = 2 * OFF_W + 1;
  localparam int RCP_SH = ASZ_W + 6;
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PRD_W  = ASZ_W + RCP_W;

  localparam logic [SUM_W-1:0]   HDR_S = SUM_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0]   HDR_O = OFF_W'(HEADER_BYTES);
  localparam logic [RCP_W-1:0]   RCP   = RCP_W'(((longint'(1) << RCP_SH) +
                                          longint'(ALIGN_BYTES) - 1) / longint'(ALIGN_BYTES));
  localparam logic [ASZ_W-1:0]   ALN_A  = ASZ_W'(ALIGN_BYTES);
  localparam logic [ASZ_W-1:0]   ALN_M1 = ASZ_W'(ALIGN_BYTES - 1);
  localparam logic [CNT_W:0]     MAX_C = (CNT_W + 1)'(MAX_BLOCKS);
  localparam logic [OFF_W-1:0]   POOL_RST = OFF_W'(POOL_BYTES < 65536 ? POOL_BYTES : 65536);

  logic [ENT_W-1:0] mem [MAX_BLOCKS];
  logic [ENT_W-1:0] rdata_r, cur_r, prev_r, wdata;
  logic [IDX_W-1:0] raddr, waddr, idx_r, src_r, mv_end_r;
  logic             we;
  logic [CNT_W-1:0] count_r;
  logic [OFF_W-1:0] pool_r, cfg_pool, csz_r;
  logic             op_r, split_r, dn_r, nm_r;
  logic [1:0]       k_r, k_free;
  logic [REQ_W-1:0] req_r;
  logic [ADDR_W-1:0] baddr_r;
  logic [ASZ_W-1:0] rnd, quot_r;
  logic [PRD_W-1:0] quot_p;
  logic [ASZ_W-1:0] asz_r;
  logic [SUM_W-1:0] end_r, addr_r, asz_e;
  logic             out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic [OFF_W-1:0] rd_off, rd_size, cur_off, cur_size, prev_off, prev_size;
  logic             rd_free, prev_free, pm;
  logic [CNT_W:0]   idx_e, cnt_e;

  assign rd_off    = rdata_r[OFF_W-1:0];
  assign rd_size   = rdata_r[2*OFF_W-1:OFF_W];
  assign rd_free   = rdata_r[2*OFF_W];
  assign cur_off   = cur_r[OFF_W-1:0];
  assign cur_size  = cur_r[2*OFF_W-1:OFF_W];
  assign prev_off  = prev_r[OFF_W-1:0];
  assign prev_size = prev_r[2*OFF_W-1:OFF_W];
  assign prev_free = prev_r[2*OFF_W];

  assign asz_e  = SUM_W'(asz_r);
  assign idx_e  = (CNT_W + 1)'(idx_r);
  assign cnt_e  = (CNT_W + 1)'(count_r);
  assign pm     = (idx_r != '0) && prev_free;
  assign k_free = {1'b0, nm_r} + {1'b0, pm};
  assign rnd    = ASZ_W'(req_r) + ALN_M1;
  assign quot_p = PRD_W'(rnd) * PRD_W'(RCP);

  always_comb begin
    if (32'(cfg_val) > 32'(POOL_BYTES)) begin
      cfg_pool = OFF_W'(POOL_BYTES);
    end else if (32'(cfg_val) < 32'(HEADER_BYTES)) begin
      cfg_pool = HDR_O;
    end else begin
      cfg_pool = OFF_W'(cfg_val);
    end
  end

  always_comb begin
    sts.op_free  = op_r;
    sts.zero_req = (req_r == '0);
    sts.match    = op_r ? (!rd_free && (SUM_W'(rd_off) + HDR_S == SUM_W'(baddr_r)))
                        : (rd_free && (SUM_W'(rd_size) >= asz_e));
    sts.last     = (idx_e + 1'b1 == cnt_e);
    sts.split    = (SUM_W'(cur_size) > asz_e + HDR_S) && (cnt_e < MAX_C);
    sts.mv_any   = op_r ? ((k_free != 2'd0) && (idx_e + 2'd2 + nm_r <= cnt_e))
                        : (idx_e + 2'd2 <= cnt_e);
    sts.mv_done  = (src_r == mv_end_r);
    sts.has_next = (idx_e + 1'b1 < cnt_e);
    sts.app_ok   = (cnt_e < MAX_C) && (end_r + HDR_S + asz_e <= SUM_W'(pool_r));
  end

  always_comb begin
    case (cmd.op)
      DP_NXRD: raddr = idx_r + 1'b1;
      DP_MVRD: raddr = src_r;
      default: raddr = idx_r;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = rdata_r;
    case (cmd.op)
      DP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, pool_r - HDR_O, OFF_W'(0)};
      end
      DP_MVWR: begin
        we    = 1'b1;
        waddr = dn_r ? (src_r - IDX_W'(k_r)) : (src_r + 1'b1);
      end
      DP_WRA: begin
        we    = 1'b1;
        waddr = idx_r + 1'b1;
        wdata = {1'b1, OFF_W'(SUM_W'(cur_size) - asz_e - HDR_S),
                 OFF_W'(SUM_W'(cur_off) + HDR_S + asz_e)};
      end
      DP_WRB: begin
        we    = 1'b1;
        wdata = {1'b0, split_r ? OFF_W'(asz_r) : cur_size, cur_off};
      end
      DP_APPEND: begin
        we    = 1'b1;
        waddr = count_r[IDX_W-1:0];
        wdata = {1'b0, OFF_W'(asz_r), OFF_W'(end_r)};
      end
      DP_MERGE: begin
        we    = 1'b1;
        waddr = pm ? (idx_r - 1'b1) : idx_r;
        wdata = {1'b1, pm ? OFF_W'(SUM_W'(prev_size) + HDR_S + SUM_W'(csz_r)) : csz_r,
                 pm ? prev_off : cur_off};
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (cfg_we) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {1'b1, cfg_pool - HDR_O, OFF_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(1);
      pool_r      <= POOL_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == DP_FINISH);
      if (cfg_we) begin
        pool_r  <= cfg_pool;
        count_r <= CNT_W'(1);
      end else begin
        case (cmd.op)
          DP_INIT:   count_r <= CNT_W'(1);
          DP_FITSET: if (sts.split) count_r <= count_r + 1'b1;
          DP_APPEND: count_r <= count_r + 1'b1;
          DP_MERGE:  count_r <= count_r - CNT_W'(k_free);
          default:   count_r <= count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_r    <= in_op;
        req_r   <= in_request_size;
        baddr_r <= in_block_address;
        idx_r   <= '0;
        addr_r  <= '0;
      end
      DP_ALN: begin
        quot_r <= quot_p[RCP_SH +: ASZ_W];
      end
      DP_ASZ: begin
        asz_r <= quot_r * ALN_A;
      end
      DP_CHK: begin
        cur_r  <= rdata_r;
        prev_r <= cur_r;
        if (!sts.match && !sts.last) idx_r <= idx_r + 1'b1;
      end
      DP_FITSET: begin
        split_r  <= sts.split;
        src_r    <= IDX_W'(count_r - 1'b1);
        mv_end_r <= idx_r + 1'b1;
        dn_r     <= 1'b0;
        k_r      <= 2'd1;
      end
      DP_MVWR: begin
        src_r <= dn_r ? (src_r + 1'b1) : (src_r - 1'b1);
      end
      DP_WRB: begin
        addr_r <= SUM_W'(cur_off) + HDR_S;
      end
      DP_TAIL: begin
        end_r <= SUM_W'(cur_off) + HDR_S + SUM_W'(cur_size);
      end
      DP_APPEND: begin
        addr_r <= end_r + HDR_S;
      end
      DP_NXCAP: begin
        nm_r  <= rd_free;
        csz_r <= rd_free ? OFF_W'(SUM_W'(cur_size) + HDR_S + SUM_W'(rd_size)) : cur_size;
      end
      DP_NONX: begin
        nm_r  <= 1'b0;
        csz_r <= cur_size;
      end
      DP_MERGE: begin
        src_r    <= idx_r + 1'b1 + IDX_W'(nm_r);
        mv_end_r <= IDX_W'(count_r - 1'b1);
        dn_r     <= 1'b1;
        k_r      <= k_free;
      end
      DP_FINISH: begin
        out_status_r <= cmd.stat;
        out_addr_r   <= (cmd.stat == STAT_OK) ? addr_r[ADDR_W-1:0] : '0;
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  assign pool_val            = 32'(pool_r);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_payload_address = out_addr_r;

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n) count_r != '0)
    else $error("block count dropped to zero");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_e <= MAX_C)
    else $error("block count above store depth");
  a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_MERGE && !cfg_we) |=> count_r == $past(count_r) - CNT_W'($past(k_free)))
    else $error("merge count update wrong");

endmodule

// ----- hw/rtl/fha_ctrl.sv -----
// fha_ctrl: sequencer for allocate and free walks over the header store
// depends on fha_pkg; commands fha_datapath
module fha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fha_pkg::dp_sts_t sts,
  output fha_pkg::dp_cmd_t cmd
);
  import fha_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_ALN, S_ASZ, S_RD, S_CHK, S_FIT, S_MVRD, S_MVWR,
    S_WRA, S_WRB, S_OK, S_TAIL, S_APP, S_BAD, S_FNX, S_NXCAP, S_MRG
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    cmd.stat  = STAT_OK;
    case (state_r)
      S_INIT: begin
        cmd.op    = DP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.op_free) begin
          state_nxt = S_RD;
        end else if (sts.zero_req) begin
          cmd.op    = DP_FINISH;
          cmd.stat  = STAT_ZERO;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ALN;
        end
      end
      S_ALN: begin
        cmd.op    = DP_ALN;
        state_nxt = S_ASZ;
      end
      S_ASZ: begin
        cmd.op    = DP_ASZ;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.op    = DP_RD;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.op = DP_CHK;
        if (sts.match) begin
          state_nxt = sts.op_free ? S_FNX : S_FIT;
        end else if (sts.last) begin
          state_nxt = sts.op_free ? S_BAD : S_TAIL;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_FIT: begin
        cmd.op = DP_FITSET;
        if (sts.split) begin
          state_nxt = sts.mv_any ? S_MVRD : S_WRA;
        end else begin
          state_nxt = S_WRB;
        end
      end
      S_MVRD: begin
        cmd.op    = DP_MVRD;
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        cmd.op = DP_MVWR;
        if (sts.mv_done) begin
          state_nxt = sts.op_free ? S_OK : S_WRA;
        end else begin
          state_nxt = S_MVRD;
        end
      end
      S_WRA: begin
        cmd.op    = DP_WRA;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        cmd.op    = DP_WRB;
        state_nxt = S_OK;
      end
      S_OK: begin
        cmd.op    = DP_FINISH;
        state_nxt = S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = DP_TAIL;
        state_nxt = S_APP;
      end
      S_APP: begin
        if (sts.app_ok) begin
          cmd.op    = DP_APPEND;
          state_nxt = S_OK;
        end else begin
          cmd.op    = DP_FINISH;
          cmd.stat  = STAT_NO_SPACE;
          state_nxt = S_IDLE;
        end
      end
      S_BAD: begin
        cmd.op    = DP_FINISH;
        cmd.stat  = STAT_BAD_FREE;
        state_nxt = S_IDLE;
      end
      S_FNX: begin
        if (sts.has_next) begin
          cmd.op    = DP_NXRD;
          state_nxt = S_NXCAP;
        end else begin
          cmd.op    = DP_NONX;
          state_nxt = S_MRG;
        end
      end
      S_NXCAP: begin
        cmd.op    = DP_NXCAP;
        state_nxt = S_MRG;
      end
      S_MRG: begin
        cmd.op    = DP_MERGE;
        state_nxt = sts.mv_any ? S_MVRD : S_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy)
    else $error("busy not raised after a request");
  a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !busy)
    else $error("busy while idle");
  a_alloc_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIT || state_r == S_TAIL) |-> !sts.op_free)
    else $error("allocate state reached on a free");

endmodule
